[rtl/core/qosl_pkg.sv]
// qosl_pkg: shared widths, codes, command/status structs and the quadrant decoder
// for the quadrant obstacle speed limiter. No dependencies.
package qosl_pkg;

    localparam int OP_W      = 2;
    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int VEL_W     = 16;
    localparam int SLOW_W    = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int QUAD_N    = 4;
    localparam int PROD_W    = 2 * VEL_W;

    typedef enum logic [OP_W-1:0] {
        OP_SCAN_START  = 2'd0,
        OP_SCAN_SAMPLE = 2'd1,
        OP_SCAN_END    = 2'd2,
        OP_VEL_CMD     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAFE_FRONT    = 3'd0,
        CFG_SAFE_REAR     = 3'd1,
        CFG_SAFE_LEFT     = 3'd2,
        CFG_SAFE_RIGHT    = 3'd3,
        CFG_SLOW_FACTOR   = 3'd4,
        CFG_RANGE_FLOOR   = 3'd5,
        CFG_RANGE_CEILING = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        Q_FRONT = 2'd0,
        Q_LEFT  = 2'd1,
        Q_REAR  = 2'd2,
        Q_RIGHT = 2'd3
    } quad_t;

    typedef struct packed {
        logic scan_en;
        logic load_cmd;
        logic axis;
        logic mul_en;
        logic decide_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

    // octant bits of the binary angle select the quadrant
    function automatic quad_t quad_of(input logic [ANGLE_W-1:0] ang);
        quad_t q;
        case (ang[ANGLE_W-1 -: 3]) inside
            3'b111, 3'b000: q = Q_FRONT;
            3'b001, 3'b010: q = Q_LEFT;
            3'b101, 3'b110: q = Q_RIGHT;
            default:        q = Q_REAR;
        endcase
        return q;
    endfunction

endpackage

[rtl/core/qosl_item_if.sv]
// qosl_item_if: input channel carrying scan and velocity transactions
// depends on qosl_pkg
interface qosl_item_if;
    logic                                 valid;
    logic                                 ready;
    logic        [qosl_pkg::OP_W-1:0]     op;
    logic        [qosl_pkg::RANGE_W-1:0]  range_mm;
    logic                                 sample_ok;
    logic signed [qosl_pkg::ANGLE_W-1:0]  start_angle;
    logic signed [qosl_pkg::ANGLE_W-1:0]  angle_step;
    logic signed [qosl_pkg::VEL_W-1:0]    vel_x;
    logic signed [qosl_pkg::VEL_W-1:0]    vel_y;

    modport source (
        output valid, op, range_mm, sample_ok, start_angle, angle_step, vel_x, vel_y,
        input  ready
    );
    modport sink (
        input  valid, op, range_mm, sample_ok, start_angle, angle_step, vel_x, vel_y,
        output ready
    );
endinterface

[rtl/core/qosl_result_if.sv]
// qosl_result_if: output channel carrying limited velocity transactions
// depends on qosl_pkg
interface qosl_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [qosl_pkg::VEL_W-1:0]  out_vel_x;
    logic signed [qosl_pkg::VEL_W-1:0]  out_vel_y;
    logic                               limited;

    modport source (
        output valid, out_vel_x, out_vel_y, limited,
        input  ready
    );
    modport sink (
        input  valid, out_vel_x, out_vel_y, limited,
        output ready
    );
endinterface

[rtl/core/qosl_div.sv]
// qosl_div: serial restoring divider, one quotient bit per cycle
// depends on qosl_pkg
module qosl_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [qosl_pkg::PROD_W-1:0]  dividend,
    input  logic [qosl_pkg::VEL_W-1:0]   divisor,
    output logic [qosl_pkg::VEL_W-1:0]   quotient,
    output logic                         done
);
    import qosl_pkg::*;

    localparam int STEPS = PROD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [VEL_W-1:0]  rem_reg;
    logic [VEL_W-1:0]  dvs_reg;
    logic [VEL_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[PROD_W-2:0], ge};
            rem_reg <= ge ? VEL_W'(trial - {1'b0, dvs_reg}) : trial[VEL_W-1:0];
        end
    end

    assign quotient = dvd_reg[VEL_W-1:0];
    assign done     = done_reg;

endmodule

[rtl/core/qosl_ctrl.sv]
// qosl_ctrl: sequencer for scan transactions and the two-axis limiting pass
// depends on qosl_pkg
module qosl_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [qosl_pkg::OP_W-1:0] in_op,
    output logic                      in_ready,
    input  qosl_pkg::dp_status_t      status,
    output qosl_pkg::ctrl_cmd_t       cmd
);
    import qosl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_DECIDE = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_op == OP_VEL_CMD))
                begin
                    state_next = S_MUL;
                    axis_next  = 1'b0;
                end
            end
            S_MUL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.need_div)
                begin
                    state_next = S_DIV;
                end
                else if (axis_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                    axis_next  = 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    if (axis_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                        axis_next  = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.scan_en   = accept && (in_op != OP_VEL_CMD);
        cmd.load_cmd  = accept && (in_op == OP_VEL_CMD);
        cmd.axis      = axis_reg;
        cmd.mul_en    = (state_reg == S_MUL);
        cmd.decide_en = (state_reg == S_DECIDE);
        cmd.load_out  = (state_reg == S_DONE) && status.out_free;
    end

endmodule

[rtl/core/qosl_datapath.sv]
// qosl_datapath: configuration, quadrant minima, per-axis scaling and output register
// depends on qosl_pkg and qosl_div
module qosl_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic        [qosl_pkg::CFG_IDX_W-1:0] wr_idx,
    input  logic        [qosl_pkg::CFG_W-1:0]    wr_data,
    input  logic        [qosl_pkg::OP_W-1:0]     op,
    input  logic        [qosl_pkg::RANGE_W-1:0]  range_mm,
    input  logic                                 sample_ok,
    input  logic signed [qosl_pkg::ANGLE_W-1:0]  start_angle,
    input  logic signed [qosl_pkg::ANGLE_W-1:0]  angle_step,
    input  logic signed [qosl_pkg::VEL_W-1:0]    vel_x,
    input  logic signed [qosl_pkg::VEL_W-1:0]    vel_y,
    input  qosl_pkg::ctrl_cmd_t                  cmd,
    output qosl_pkg::dp_status_t                 status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [qosl_pkg::VEL_W-1:0]    out_vel_x,
    output logic signed [qosl_pkg::VEL_W-1:0]    out_vel_y,
    output logic                                 out_limited
);
    import qosl_pkg::*;

    localparam int FAR_W = RANGE_W + SLOW_W;

    // configuration
    logic [RANGE_W-1:0] safe_front_reg, safe_rear_reg, safe_left_reg, safe_right_reg;
    logic [SLOW_W-1:0]  slow_factor_reg;
    logic [RANGE_W-1:0] range_floor_reg, range_ceiling_reg;

    // scan state
    logic [RANGE_W-1:0] work_min_reg  [QUAD_N];
    logic [QUAD_N-1:0]  work_seen_reg;
    logic [RANGE_W-1:0] held_min_reg  [QUAD_N];
    logic [QUAD_N-1:0]  held_seen_reg;
    logic [ANGLE_W-1:0] sample_angle_reg;
    logic [ANGLE_W-1:0] angle_inc_reg;
    logic               scan_ready_reg;

    // command and axis pipeline
    logic signed [VEL_W-1:0] vx_reg, vy_reg;
    logic signed [VEL_W-1:0] res_x_reg, res_y_reg;
    logic [RANGE_W-1:0]      far_reg, d_reg, safe_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    pass_reg, le_reg, neg_reg;

    logic                    out_valid_reg;
    logic signed [VEL_W-1:0] out_vel_x_reg, out_vel_y_reg;
    logic                    out_limited_reg;

    logic signed [VEL_W-1:0] v;
    logic                    pos;
    quad_t                   q;
    quad_t                   sq;
    logic [RANGE_W-1:0]      safe;
    logic [RANGE_W-1:0]      d;
    logic [VEL_W-1:0]        mag;
    logic [RANGE_W-1:0]      diff;
    logic [FAR_W-1:0]        far_full;
    logic                    need_div;
    logic signed [VEL_W-1:0] decide_val;
    logic [VEL_W-1:0]        quotient;
    logic                    div_done;
    logic signed [VEL_W-1:0] div_val;
    logic                    in_range;

    // axis selection
    always_comb
    begin
        v   = cmd.axis ? vy_reg : vx_reg;
        pos = !v[VEL_W-1] && (v != '0);
        if (cmd.axis)
        begin
            q    = pos ? Q_LEFT : Q_RIGHT;
            safe = pos ? safe_left_reg : safe_right_reg;
        end
        else
        begin
            q    = pos ? Q_FRONT : Q_REAR;
            safe = pos ? safe_front_reg : safe_rear_reg;
        end
        d        = held_min_reg[q];
        mag      = v[VEL_W-1] ? VEL_W'(-v) : VEL_W'(v);
        diff     = d - safe;
        far_full = FAR_W'(safe) * FAR_W'(slow_factor_reg);
    end

    assign need_div   = !pass_reg && !le_reg && (d_reg < far_reg);
    assign decide_val = pass_reg ? v : (le_reg ? '0 : v);
    assign div_val    = neg_reg ? VEL_W'(-$signed(quotient)) : $signed(quotient);

    assign sq       = quad_of(sample_angle_reg);
    assign in_range = sample_ok && (range_mm >= range_floor_reg)
                      && (range_mm <= range_ceiling_reg);

    qosl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.decide_en && need_div),
        .dividend (prod_reg),
        .divisor  (far_reg - safe_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_front_reg    <= RANGE_W'(200);
            safe_rear_reg     <= RANGE_W'(200);
            safe_left_reg     <= RANGE_W'(150);
            safe_right_reg    <= RANGE_W'(150);
            slow_factor_reg   <= SLOW_W'(512);
            range_floor_reg   <= '0;
            range_ceiling_reg <= '1;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                CFG_SAFE_FRONT:    safe_front_reg    <= wr_data[RANGE_W-1:0];
                CFG_SAFE_REAR:     safe_rear_reg     <= wr_data[RANGE_W-1:0];
                CFG_SAFE_LEFT:     safe_left_reg     <= wr_data[RANGE_W-1:0];
                CFG_SAFE_RIGHT:    safe_right_reg    <= wr_data[RANGE_W-1:0];
                CFG_SLOW_FACTOR:   slow_factor_reg   <= wr_data[SLOW_W-1:0];
                CFG_RANGE_FLOOR:   range_floor_reg   <= wr_data[RANGE_W-1:0];
                CFG_RANGE_CEILING: range_ceiling_reg <= wr_data[RANGE_W-1:0];
                default:           ;
            endcase
        end
    end

    // scan transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUAD_N; i++)
            begin
                work_min_reg[i] <= '1;
                held_min_reg[i] <= '1;
            end
            work_seen_reg    <= '0;
            held_seen_reg    <= '0;
            sample_angle_reg <= '0;
            angle_inc_reg    <= '0;
            scan_ready_reg   <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            case (op)
                OP_SCAN_START:
                begin
                    sample_angle_reg <= start_angle;
                    angle_inc_reg    <= angle_step;
                    for (int i = 0; i < QUAD_N; i++)
                    begin
                        work_min_reg[i] <= '1;
                    end
                    work_seen_reg <= '0;
                end
                OP_SCAN_SAMPLE:
                begin
                    if (in_range)
                    begin
                        if (!work_seen_reg[sq] || (range_mm < work_min_reg[sq]))
                        begin
                            work_min_reg[sq] <= range_mm;
                        end
                        work_seen_reg[sq] <= 1'b1;
                    end
                    sample_angle_reg <= sample_angle_reg + angle_inc_reg;
                end
                OP_SCAN_END:
                begin
                    for (int i = 0; i < QUAD_N; i++)
                    begin
                        held_min_reg[i] <= work_min_reg[i];
                        work_min_reg[i] <= '1;
                    end
                    held_seen_reg  <= work_seen_reg;
                    work_seen_reg  <= '0;
                    scan_ready_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // per-axis arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load_cmd)
        begin
            vx_reg <= vel_x;
            vy_reg <= vel_y;
        end
        if (cmd.mul_en)
        begin
            far_reg  <= (|far_full[FAR_W-1:RANGE_W+8]) ? '1 : far_full[RANGE_W+7:8];
            prod_reg <= PROD_W'(mag) * PROD_W'(diff);
            d_reg    <= d;
            safe_reg <= safe;
            neg_reg  <= v[VEL_W-1];
            pass_reg <= !scan_ready_reg || (v == '0) || !held_seen_reg[q];
            le_reg   <= (d <= safe);
        end
        if (cmd.decide_en && !need_div)
        begin
            if (cmd.axis)
            begin
                res_y_reg <= decide_val;
            end
            else
            begin
                res_x_reg <= decide_val;
            end
        end
        if (div_done)
        begin
            if (cmd.axis)
            begin
                res_y_reg <= div_val;
            end
            else
            begin
                res_x_reg <= div_val;
            end
        end
        if (cmd.load_out)
        begin
            out_vel_x_reg   <= res_x_reg;
            out_vel_y_reg   <= res_y_reg;
            out_limited_reg <= scan_ready_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_vel_x   = out_vel_x_reg;
    assign out_vel_y   = out_vel_y_reg;
    assign out_limited = out_limited_reg;

endmodule

[rtl/core/quadrant_obstacle_speed_limiter_top.sv]
// quadrant_obstacle_speed_limiter_top: top level joining controller and datapath
// scan transactions are taken while idle; a velocity command runs each axis through
// multiply and decide, and the 32-step serial divider if the slow-zone ramp needs it
// one command in flight at a time; the result register frees the input side
// reset: configuration to its defaults, quadrant minima at 65535, no scan committed
// depends on qosl_pkg, qosl_item_if, qosl_result_if, qosl_ctrl, qosl_datapath
module quadrant_obstacle_speed_limiter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [qosl_pkg::CFG_IDX_W-1:0]    wr_idx,
    input  logic [qosl_pkg::CFG_W-1:0]        wr_data,
    qosl_item_if.sink                         item,
    qosl_result_if.source                     result
);
    import qosl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    qosl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_op    (item.op),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    qosl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_data     (wr_data),
        .op          (item.op),
        .range_mm    (item.range_mm),
        .sample_ok   (item.sample_ok),
        .start_angle (item.start_angle),
        .angle_step  (item.angle_step),
        .vel_x       (item.vel_x),
        .vel_y       (item.vel_y),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .out_vel_x   (result.out_vel_x),
        .out_vel_y   (result.out_vel_y),
        .out_limited (result.limited)
    );

    // a command holds the input side until its result is registered
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.op == OP_VEL_CMD)) |=> !item.ready)
        else $error("input accepted during a velocity command");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("result register overwritten");

    // divider completes only while a command is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> !item.ready)
        else $error("divider completion outside a command");

endmodule

[dv/tb_quadrant_obstacle_speed_limiter_top.sv]
// tb_quadrant_obstacle_speed_limiter_top: self-checking bench for the quadrant obstacle speed limiter
// drives scan and velocity transactions, tracks quadrant minima and predicts the result of every velocity command
// depends on qosl_pkg, qosl_item_if, qosl_result_if, quadrant_obstacle_speed_limiter_top
module tb_quadrant_obstacle_speed_limiter_top;
    import qosl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 38;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        op_t                op;
        logic [15:0]        range_mm;
        logic               sample_ok;
        logic signed [15:0] start_angle;
        logic signed [15:0] angle_step;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } lidar_item_t;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               lim;
    } vel_result_t;

    class speed_limit_checker;
        logic [15:0] cfg [7];
        logic [15:0] work_min [4];
        bit          work_seen [4];
        logic [15:0] held_min [4];
        bit          held_seen [4];
        logic [15:0] angle;
        logic [15:0] step;
        bit          committed;
        vel_result_t expected_vel [$];
        int          errors;

        function new();
            cfg[CFG_SAFE_FRONT]    = 16'd200;
            cfg[CFG_SAFE_REAR]     = 16'd200;
            cfg[CFG_SAFE_LEFT]     = 16'd150;
            cfg[CFG_SAFE_RIGHT]    = 16'd150;
            cfg[CFG_SLOW_FACTOR]   = 16'd512;
            cfg[CFG_RANGE_FLOOR]   = 16'd0;
            cfg[CFG_RANGE_CEILING] = 16'hFFFF;
            clear_work();
            for (int i = 0; i < 4; i++)
            begin
                held_min[i]  = 16'hFFFF;
                held_seen[i] = 1'b0;
            end
            angle     = '0;
            step      = '0;
            committed = 1'b0;
            errors    = 0;
        endfunction

        function void clear_work();
            for (int i = 0; i < 4; i++)
            begin
                work_min[i]  = 16'hFFFF;
                work_seen[i] = 1'b0;
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            cfg[idx] = (idx == CFG_SLOW_FACTOR) ? (val & 16'h0FFF) : val;
        endfunction

        function quad_t sector_of(logic [15:0] ang);
            int a;
            a = $signed(ang);
            if (a >= -8192 && a < 8192)
                return Q_FRONT;
            if (a >= 8192 && a < 24576)
                return Q_LEFT;
            if (a >= -24576 && a < -8192)
                return Q_RIGHT;
            return Q_REAR;
        endfunction

        function logic signed [15:0] scale_axis(logic signed [15:0] v, quad_t q,
                                                logic [15:0] safe);
            longint d;
            longint s;
            longint fac;
            longint far_mm;
            longint mag;
            longint res;
            if (!held_seen[q])
                return v;
            d   = held_min[q];
            s   = safe;
            fac = cfg[CFG_SLOW_FACTOR][11:0];
            if (d <= s)
                return 0;
            far_mm = (s * fac) >> 8;
            if (far_mm > 65535)
                far_mm = 65535;
            if (d >= far_mm)
                return v;
            mag = v;
            if (mag < 0)
                mag = -mag;
            res = (mag * (d - s)) / (far_mm - s);
            return 16'((v < 0) ? -res : res);
        endfunction

        function void absorb_item(lidar_item_t it);
            quad_t       q;
            vel_result_t r;
            case (it.op)
                OP_SCAN_START:
                begin
                    angle = it.start_angle;
                    step  = it.angle_step;
                    clear_work();
                end
                OP_SCAN_SAMPLE:
                begin
                    if (it.sample_ok && it.range_mm >= cfg[CFG_RANGE_FLOOR]
                        && it.range_mm <= cfg[CFG_RANGE_CEILING])
                    begin
                        q = sector_of(angle);
                        if (!work_seen[q] || it.range_mm < work_min[q])
                            work_min[q] = it.range_mm;
                        work_seen[q] = 1'b1;
                    end
                    angle = angle + step;
                end
                OP_SCAN_END:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        held_min[i]  = work_min[i];
                        held_seen[i] = work_seen[i];
                    end
                    committed = 1'b1;
                    clear_work();
                end
                default:
                begin
                    r.vx  = it.vel_x;
                    r.vy  = it.vel_y;
                    r.lim = committed;
                    if (committed)
                    begin
                        if (it.vel_x > 0)
                            r.vx = scale_axis(it.vel_x, Q_FRONT, cfg[CFG_SAFE_FRONT]);
                        else if (it.vel_x < 0)
                            r.vx = scale_axis(it.vel_x, Q_REAR, cfg[CFG_SAFE_REAR]);
                        if (it.vel_y > 0)
                            r.vy = scale_axis(it.vel_y, Q_LEFT, cfg[CFG_SAFE_LEFT]);
                        else if (it.vel_y < 0)
                            r.vy = scale_axis(it.vel_y, Q_RIGHT, cfg[CFG_SAFE_RIGHT]);
                    end
                    expected_vel.push_back(r);
                end
            endcase
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", msg);
        endtask

        task check_velocity(vel_result_t got);
            vel_result_t exp_r;
            if (expected_vel.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected transaction x=%0d y=%0d limited=%0b",
                                        got.vx, got.vy, got.lim));
                return;
            end
            exp_r = expected_vel.pop_front();
            if (got.vx !== exp_r.vx)
                flag_mismatch($sformatf("out_vel_x %0d, predicted %0d", got.vx, exp_r.vx));
            if (got.vy !== exp_r.vy)
                flag_mismatch($sformatf("out_vel_y %0d, predicted %0d", got.vy, exp_r.vy));
            if (got.lim !== exp_r.lim)
                flag_mismatch($sformatf("limited %0b, predicted %0b", got.lim, exp_r.lim));
        endtask

        function int pending();
            return expected_vel.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_idx;
    logic [CFG_W-1:0]     wr_data;
    bit                   steady;
    bit                   hold_req;
    speed_limit_checker   sb;

    qosl_item_if   item_ch ();
    qosl_result_if result_ch ();

    quadrant_obstacle_speed_limiter_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .item    (item_ch.sink),
        .result  (result_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic lidar_item_t random_item(input op_t op);
        lidar_item_t it;
        it.op          = op;
        it.range_mm    = 16'($urandom);
        it.sample_ok   = 1'($urandom);
        it.start_angle = 16'($urandom);
        it.angle_step  = 16'($urandom);
        it.vel_x       = 16'($urandom);
        it.vel_y       = 16'($urandom);
        return it;
    endfunction

    function automatic lidar_item_t start_item(input logic [15:0] ang, input logic [15:0] stp);
        lidar_item_t it;
        it             = random_item(OP_SCAN_START);
        it.start_angle = ang;
        it.angle_step  = stp;
        return it;
    endfunction

    function automatic lidar_item_t sample_item(input logic [15:0] rng, input logic ok);
        lidar_item_t it;
        it           = random_item(OP_SCAN_SAMPLE);
        it.range_mm  = rng;
        it.sample_ok = ok;
        return it;
    endfunction

    function automatic lidar_item_t cmd_item(input logic signed [15:0] vx,
                                             input logic signed [15:0] vy);
        lidar_item_t it;
        it       = random_item(OP_VEL_CMD);
        it.vel_x = vx;
        it.vel_y = vy;
        return it;
    endfunction

    // ranges cluster around the stop and slow-zone thresholds, with some random, short and edge values
    function automatic logic [15:0] pick_range();
        int s;
        int far_mm;
        s      = sb.cfg[$urandom_range(0, 3)];
        far_mm = (s * sb.cfg[CFG_SLOW_FACTOR]) >> 8;
        if (far_mm > 65535)
            far_mm = 65535;
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1, 2:    return 16'($urandom_range(s, far_mm));
            3:       return 16'(s + $urandom_range(0, 2) - 1);
            4:       return 16'($urandom_range(0, 3000));
            default:
                case ($urandom_range(0, 3))
                    0:       return 16'd0;
                    1:       return 16'hFFFF;
                    2:       return sb.cfg[CFG_RANGE_FLOOR];
                    default: return sb.cfg[CFG_RANGE_CEILING];
                endcase
        endcase
    endfunction

    function automatic logic signed [15:0] pick_vel();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 4000) - 2000);
            1:
                case ($urandom_range(0, 4))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return 0;
                    3:       return 1;
                    default: return -1;
                endcase
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input lidar_item_t it);
        while (!steady && $urandom_range(0, 99) < 8)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.op          <= it.op;
        item_ch.range_mm    <= it.range_mm;
        item_ch.sample_ok   <= it.sample_ok;
        item_ch.start_angle <= it.start_angle;
        item_ch.angle_step  <= it.angle_step;
        item_ch.vel_x       <= it.vel_x;
        item_ch.vel_y       <= it.vel_y;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.absorb_item(it);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        wr_en   <= 1'b1;
        wr_idx  <= idx;
        wr_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [15:0] s_front, input logic [15:0] s_rear,
                             input logic [15:0] s_left, input logic [15:0] s_right,
                             input logic [15:0] factor, input logic [15:0] floor_mm,
                             input logic [15:0] ceil_mm);
        write_reg(CFG_SAFE_FRONT, s_front);
        write_reg(CFG_SAFE_REAR, s_rear);
        write_reg(CFG_SAFE_LEFT, s_left);
        write_reg(CFG_SAFE_RIGHT, s_right);
        write_reg(CFG_SLOW_FACTOR, factor);
        write_reg(CFG_RANGE_FLOOR, floor_mm);
        write_reg(CFG_RANGE_CEILING, ceil_mm);
        wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_safe();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2000));
    endfunction

    task automatic setup_phase(input int ph);
        logic [15:0] s;
        case (ph)
            0: configure(0, 0, 0, 0, 0, 0, 16'hFFFF);
            1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4095, 0, 16'hFFFF);
            // floor above ceiling drops every sample
            2: configure(pick_safe(), pick_safe(), pick_safe(), pick_safe(), 512, 3000, 1000);
            // slow factor below one gives a hard stop only
            3:
            begin
                s = 16'($urandom_range(100, 1500));
                configure(s, s + 16'd7, s - 16'd9, s + 16'd31,
                          16'($urandom_range(0, 255)), 0, 16'hFFFF);
            end
            // slow-zone end saturates for most draws
            5: configure(16'($urandom_range(8000, 30000)), 16'($urandom_range(8000, 30000)),
                         16'($urandom_range(8000, 30000)), 16'($urandom_range(8000, 30000)),
                         16'($urandom_range(2048, 4095)), 16'($urandom_range(0, 500)),
                         16'($urandom_range(60000, 65535)));
            default:
                configure(pick_safe(), pick_safe(), pick_safe(), pick_safe(),
                          16'($urandom_range(0, 4095)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 1000)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF);
        endcase
    endtask

    task automatic run_phase(input int budget);
        int          sent;
        int          n;
        int          k;
        logic [15:0] stp;
        sent = 0;
        while (sent < budget)
        begin
            n = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       stp = 16'($urandom);
                1:       stp = 16'(65536 / n);
                2:       stp = 16'(-(65536 / n));
                default: stp = 16'($urandom_range(0, 1024) - 512);
            endcase
            // mostly complete scans, some with the start or end missing, plus noise
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(start_item(16'($urandom), stp));
                sent++;
            end
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_item(random_item(op_t'($urandom_range(0, 3))));
                else
                    send_item(sample_item(pick_range(), $urandom_range(0, 7) != 0));
                sent++;
            end
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(random_item(OP_SCAN_END));
                sent++;
            end
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
            begin
                send_item(cmd_item(pick_vel(), pick_vel()));
                sent++;
            end
        end
    endtask

    task automatic drain(input int tail);
        int waited;
        waited = 0;
        while (sb.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (tail) @(posedge clk);
    endtask

    // result side: random back-pressure, one long hold on request
    initial
    begin
        int hold;
        vel_result_t got;
        hold = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.vx  = result_ch.out_vel_x;
                got.vy  = result_ch.out_vel_y;
                got.lim = result_ch.limited;
                sb.check_velocity(got);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (steady)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= 8);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int ph;
        int k;
        sb                  = new();
        steady              = 1'b0;
        hold_req            = 1'b0;
        rst_n               <= 1'b0;
        wr_en               <= 1'b0;
        wr_idx              <= CFG_SAFE_FRONT;
        wr_data             <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.op          <= OP_SCAN_START;
        item_ch.range_mm    <= '0;
        item_ch.sample_ok   <= 1'b0;
        item_ch.start_angle <= '0;
        item_ch.angle_step  <= '0;
        item_ch.vel_x       <= '0;
        item_ch.vel_y       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // command before any scan passes unchanged
        send_item(cmd_item(32767, -32768));
        // quadrant edges from the inside, right quadrant dropped
        send_item(start_item(16'hE000, 16'h4000));
        send_item(sample_item(250, 1'b1));
        send_item(sample_item(300, 1'b1));
        send_item(sample_item(16'hFFFF, 1'b1));
        send_item(sample_item(100, 1'b0));
        send_item(random_item(OP_SCAN_END));
        send_item(cmd_item(1000, 1000));
        send_item(cmd_item(-1000, -1000));
        send_item(cmd_item(-32768, 0));
        // quadrant edges from the outside
        send_item(start_item(16'hDFFF, 16'h4000));
        send_item(sample_item(0, 1'b1));
        send_item(sample_item(399, 1'b1));
        send_item(sample_item(151, 1'b1));
        send_item(sample_item(200, 1'b1));
        send_item(random_item(OP_SCAN_END));
        send_item(cmd_item(32767, -1));
        send_item(cmd_item(-5, 32767));
        // sample with no scan start carries on from the old angle
        send_item(sample_item(160, 1'b1));
        send_item(random_item(OP_SCAN_END));
        send_item(cmd_item(100, -100));
        send_item(cmd_item(0, 0));

        for (ph = 0; ph < PHASES; ph++)
        begin
            item_ch.valid <= 1'b0;
            drain(80);
            setup_phase(ph);
            if (ph == 7)
                steady = 1'b1;
            if (ph == 4)
            begin
                hold_req = 1'b1;
                for (k = 0; k < 12; k++)
                    send_item(cmd_item(pick_vel(), pick_vel()));
            end
            run_phase(PHASE_ITEMS);
            steady = 1'b0;
        end

        item_ch.valid <= 1'b0;
        drain(100);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d predicted transactions never arrived",
                                       sb.pending()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/core/qosl_pkg.sv
rtl/core/qosl_item_if.sv
rtl/core/qosl_result_if.sv
rtl/core/qosl_div.sv
rtl/core/qosl_ctrl.sv
rtl/core/qosl_datapath.sv
rtl/core/quadrant_obstacle_speed_limiter_top.sv
dv/tb_quadrant_obstacle_speed_limiter_top.sv
